@@ design/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the longest prefix router
// Word layouts for the request and response channels, the lookup token
// that walks the route cell chain, and the prefix mask helper.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 6;
  localparam int IFACE_W   = 4;
  localparam int TTL_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int IFACE_VALS = 2 ** IFACE_W;

  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(32);
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_FORWARD = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FORWARDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] route_prefix_in;
    logic [LEN_W-1:0]  route_length_in;
    logic              hop_present_in;
    logic [ADDR_W-1:0] hop_address_in;
    logic [IFACE_W-1:0] iface_in;
    logic [ADDR_W-1:0] dest_address;
    logic [TTL_W-1:0]  ttl_in;
  } lpr_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IFACE_W-1:0]  out_iface;
    logic [ADDR_W-1:0]   out_hop;
    logic [TTL_W-1:0]    ttl_out;
  } lpr_rsp_t;

  // One stored route, as written into a cell
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   length;
    logic               hop_present;
    logic [ADDR_W-1:0]  hop_addr;
    logic [IFACE_W-1:0] iface;
  } lpr_route_t;

  // Lookup in flight, carrying the best match seen so far
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  dest;
    logic               found;
    logic [LEN_W-1:0]   best_len;
    logic               hop_present;
    logic [ADDR_W-1:0]  hop_addr;
    logic [IFACE_W-1:0] iface;
  } lpr_token_t;

  // Length is at most 32 here; a shift by 32 clears the word
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~(ALL_ONES >> len);
  endfunction

endpackage

@@ design/lpr_stream_if.sv @@
// ----------------------------------------------------------------------------
// lpr_stream_if: valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface lpr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/lpr_cell.sv @@
// ----------------------------------------------------------------------------
// lpr_cell: one route slot of the lookup chain
// Holds one route, compares it against the passing lookup and forwards the
// updated lookup to the next cell through its output register.
// ----------------------------------------------------------------------------
module lpr_cell
  import lpr_pkg::*;
#(
  parameter int INDEX  = 0,
  parameter int CNT_W  = 7,
  parameter int SLOT_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  lpr_route_t        wr_route,
  input  logic [CNT_W-1:0]  count,
  input  lpr_token_t        tok_in,
  output lpr_token_t        tok_out
);

  lpr_route_t route;
  lpr_token_t tok_next;
  logic       active;
  logic       hit;

  always_ff @(posedge clk) begin
    if (wr_en && wr_slot == SLOT_W'(INDEX)) begin
      route <= wr_route;
    end
  end

  always_comb begin
    active = count > CNT_W'(INDEX);
    hit = active &&
          (((route.prefix ^ tok_in.dest) & prefix_mask(route.length)) == '0) &&
          (!tok_in.found || route.length > tok_in.best_len);
    tok_next = tok_in;
    if (hit) begin
      tok_next.found       = 1'b1;
      tok_next.best_len    = route.length;
      tok_next.hop_present = route.hop_present;
      tok_next.hop_addr    = route.hop_addr;
      tok_next.iface       = route.iface;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ design/ipv4_longest_prefix_router.sv @@
// Add and expired-TTL words answer in the cycle after acceptance.
// A forward lookup walks the chain of ROUTE_DEPTH route cells, one cell per
// cycle, and answers once the lookup leaves the last cell.
// One word is in work at a time: a forward holds the block busy until its
// lookup leaves the last cell of the chain.
// Reset empties the table (route count to zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router: routing table with longest prefix lookup
// Routes are appended to a chain of cells; a lookup walks the chain and
// keeps the longest match, earliest route winning ties.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router
  import lpr_pkg::*;
#(
  parameter int ROUTE_DEPTH = 64,
  parameter int IFACE_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  lpr_stream_if.sink   req,
  lpr_stream_if.source rsp
);

  localparam int CNT_W  = $clog2(ROUTE_DEPTH + 1);
  localparam int SLOT_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;

  lpr_req_t             rq;
  lpr_rsp_t             res;
  logic                 res_valid;
  logic                 busy;
  logic [CNT_W-1:0]     route_count;
  logic [TTL_W-1:0]     ttl_hold;
  logic                 accept;
  logic                 full;
  logic                 wr_en;
  lpr_route_t           wr_route;
  logic [IFACE_W-1:0]   iface_mod [IFACE_VALS];
  lpr_token_t           tok [ROUTE_DEPTH+1];
  lpr_token_t           tok_end;

  // Interface index folded into range at elaboration
  for (genvar v = 0; v < IFACE_VALS; v++) begin : g_iface_mod
    assign iface_mod[v] = IFACE_W'(v % IFACE_COUNT);
  end

  assign rq        = req.data;
  assign req.ready = !busy && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign full      = route_count == CNT_W'(ROUTE_DEPTH);
  assign wr_en     = accept && rq.cmd == CMD_ADD && !full;

  always_comb begin
    wr_route.prefix      = rq.route_prefix_in;
    wr_route.length      = (rq.route_length_in > MAX_LEN) ? MAX_LEN : rq.route_length_in;
    wr_route.hop_present = rq.hop_present_in;
    wr_route.hop_addr    = rq.hop_address_in;
    wr_route.iface       = iface_mod[rq.iface_in];
  end

  // Inject a lookup at the head of the chain
  always_comb begin
    tok[0].valid       = accept && rq.cmd == CMD_FORWARD && rq.ttl_in > TTL_W'(1);
    tok[0].dest        = rq.dest_address;
    tok[0].found       = 1'b0;
    tok[0].best_len    = '0;
    tok[0].hop_present = 1'b0;
    tok[0].hop_addr    = '0;
    tok[0].iface       = '0;
  end

  for (genvar i = 0; i < ROUTE_DEPTH; i++) begin : g_cell
    lpr_cell #(
      .INDEX  (i),
      .CNT_W  (CNT_W),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_slot  (route_count[SLOT_W-1:0]),
      .wr_route (wr_route),
      .count    (route_count),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  assign tok_end = tok[ROUTE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      res_valid   <= 1'b0;
      route_count <= '0;
    end else begin
      if (res_valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      if (wr_en) begin
        route_count <= route_count + CNT_W'(1);
      end
      if (accept) begin
        if (rq.cmd == CMD_ADD || rq.ttl_in <= TTL_W'(1)) begin
          res_valid <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end
      if (busy && tok_end.valid) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ttl_hold      <= rq.ttl_in - TTL_W'(1);
      res.out_iface <= '0;
      res.out_hop   <= '0;
      res.ttl_out   <= '0;
      if (rq.cmd == CMD_ADD) begin
        res.status <= full ? ST_FULL : ST_ADDED;
      end else begin
        res.status <= ST_EXPIRED;
      end
    end else if (busy && tok_end.valid) begin
      res.ttl_out <= ttl_hold;
      if (tok_end.found) begin
        res.status    <= ST_FORWARDED;
        res.out_iface <= tok_end.iface;
        res.out_hop   <= tok_end.hop_present ? tok_end.hop_addr : tok_end.dest;
      end else begin
        res.status    <= ST_NO_ROUTE;
        res.out_iface <= '0;
        res.out_hop   <= '0;
      end
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.data  = res;

endmodule
